// ===== rtl/scp_pkg.sv =====
// Shared types, constants and the exp(-x) table for the screened Coulomb pair force.
// Used by scp_div and screened_coulomb_pair_force.
`default_nettype none

package scp_pkg;

    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PREFACTOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA     = 1'd1;

    localparam logic [31:0] PREFACTOR_RST = 32'd70885981;
    localparam logic [23:0] KAPPA_RST     = 24'd419430;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [14:0] EXP_N_MAX = 15'd32;
    localparam logic [63:0] OUT_MAX   = 64'h0000_7FFF_FFFF_FFFF;

    localparam int DIV_STEPS = 64;
    localparam int DIV_LANES = 2;
    localparam int LANE_G    = 0;
    localparam int LANE_E    = 1;

    typedef struct packed {
        logic            zero;
        logic            want;
        logic            neg_q;
        logic [2:0]      neg_d;
        logic [2:0][31:0] dm;
    } scp_side_t;

    typedef struct packed {
        logic        sat;
        logic [48:0] rem;
        logic [63:0] lq;
        logic [47:0] den;
    } scp_lane_t;

    typedef logic [32:0] exp_tab_t [EXP_TABLE_DEPTH];

    // 2^(-i/DEPTH) in Q1.32 from the exp(-t) series up to its t^20 term
    function automatic exp_tab_t exp_tab_build();
        exp_tab_t    tab;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            t    = (64'(i) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
            term = 64'h1_0000_0000;
            sum  = 64'h1_0000_0000;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * t) >> 32) / 64'(k);
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            tab[i] = sum[32:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = exp_tab_build();

    // clamp magnitude and apply sign; bit 48 flags a clamp
    function automatic logic [48:0] scp_pack(input logic [63:0] mag, input logic neg);
        logic [47:0] m;
        logic        clamp;
        clamp = (mag > OUT_MAX);
        m     = clamp ? OUT_MAX[47:0] : mag[47:0];
        return {clamp, neg ? (48'd0 - m) : m};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scp_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on scp_pkg for lane and sideband types.
`default_nettype none

module scp_div import scp_pkg::*; (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                en,
    input  wire                                in_valid,
    input  wire  scp_side_t                    in_side,
    input  wire  [DIV_LANES-1:0][127:0]        in_num,
    input  wire  [DIV_LANES-1:0][47:0]         in_den,
    output logic                               out_valid,
    output scp_side_t                          out_side,
    output logic [DIV_LANES-1:0][63:0]         out_quo,
    output logic [DIV_LANES-1:0]               out_sat
);

    logic [DIV_STEPS:0] vld_reg;
    scp_lane_t          lane_reg  [DIV_STEPS+1][DIV_LANES];
    scp_lane_t          lane_next [DIV_STEPS+1][DIV_LANES];
    scp_side_t          side_reg  [DIV_STEPS+1];

    function automatic scp_lane_t div_step(input scp_lane_t a);
        scp_lane_t   b;
        logic [48:0] sh;
        logic        ge;
        sh    = {a.rem[47:0], a.lq[63]};
        ge    = (sh >= {1'b0, a.den});
        b     = a;
        b.rem = ge ? (sh - {1'b0, a.den}) : sh;
        b.lq  = {a.lq[62:0], ge};
        return b;
    endfunction

    always_comb begin
        for (int l = 0; l < DIV_LANES; l++) begin
            lane_next[0][l].sat = (in_num[l][127:64] >= {16'd0, in_den[l]});
            lane_next[0][l].rem = in_num[l][112:64];
            lane_next[0][l].lq  = in_num[l][63:0];
            lane_next[0][l].den = in_den[l];
            for (int s = 1; s <= DIV_STEPS; s++) begin
                lane_next[s][l] = div_step(lane_reg[s-1][l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s <= DIV_STEPS; s++) begin
                for (int l = 0; l < DIV_LANES; l++) begin
                    lane_reg[s][l] <= lane_next[s][l];
                end
            end
            side_reg[0] <= in_side;
            for (int s = 1; s <= DIV_STEPS; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < DIV_LANES; l++) begin
            out_quo[l] = lane_reg[DIV_STEPS][l].lq;
            out_sat[l] = lane_reg[DIV_STEPS][l].sat;
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_side  = side_reg[DIV_STEPS];

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[DIV_STEPS] && !lane_reg[DIV_STEPS][LANE_G].sat
        |-> lane_reg[DIV_STEPS][LANE_G].rem < {1'b0, lane_reg[DIV_STEPS][LANE_G].den})
        else $error("divider remainder not below divisor");

    a_zero_den_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[DIV_STEPS] && lane_reg[DIV_STEPS][LANE_E].den == '0
        |-> lane_reg[DIV_STEPS][LANE_E].sat)
        else $error("zero divisor without saturation");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg) && $stable(out_quo))
        else $error("divider advanced while stalled");

endmodule

`default_nettype wire

// ===== rtl/screened_coulomb_pair_force.sv =====
// Pipeline: 9 front stages, 65 divider stages and 3 back stages from request accept to
// result valid. Throughput: one request per cycle while the pipeline is not held.
// The whole pipeline holds while the result register is full and not taken.
// Reset clears all valid bits and loads prefactor and kappa with their defaults.
// Depends on scp_pkg and scp_div.
`default_nettype none

module screened_coulomb_pair_force import scp_pkg::*; (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [31:0]          cfg_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire  [31:0]          s_distance,
    input  wire  [47:0]          s_distance_squared,
    input  wire  signed [31:0]   s_dir_x,
    input  wire  signed [31:0]   s_dir_y,
    input  wire  signed [31:0]   s_dir_z,
    input  wire  signed [23:0]   s_charge_a,
    input  wire  signed [23:0]   s_charge_b,
    input  wire  [17:0]          s_weight,
    input  wire                  s_energy_wanted,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic signed [47:0]   m_force_x,
    output logic signed [47:0]   m_force_y,
    output logic signed [47:0]   m_force_z,
    output logic signed [47:0]   m_energy,
    output logic                 m_error
);

    typedef struct packed {
        scp_side_t   side;
        logic [47:0] d2;
        logic [31:0] distance;
        logic [55:0] x;
        logic [17:0] w;
    } ctx_t;

    logic [31:0] prefactor_reg;
    logic [23:0] kappa_reg;
    logic        en;

    logic [23:0] qa_mag, qb_mag;
    logic [2:0][31:0] dir_u;
    ctx_t        ctx1_next;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    ctx_t        ctx1_reg, ctx2_reg, ctx3_reg, ctx4_reg, ctx5_reg, ctx6_reg, ctx7_reg;
    ctx_t        ctx8_reg, ctx9_reg;
    logic [47:0] qq1_reg;
    logic [60:0] y2_reg;
    logic [55:0] ppa2_reg, ppb2_reg;
    logic [55:0] p1_3_reg;
    logic [14:0] n3_reg;
    logic [32:0] tab3_reg;
    logic [32:0] ex4_reg, ex5_reg;
    logic [45:0] ppa4_reg, ppb4_reg;
    logic [57:0] p2_5_reg;
    logic [61:0] ppa6_reg, ppb6_reg;
    logic [90:0] s7_sum;
    logic [58:0] p3_7_reg, p3_8_reg, p3_9_reg;
    logic [44:0] onepk;
    logic [52:0] ac8_reg;
    logic [51:0] ad8_reg, bc8_reg;
    logic [50:0] bd8_reg;
    logic [103:0] prod9_reg;

    logic [DIV_LANES-1:0][127:0] div_num;
    logic [DIV_LANES-1:0][47:0]  div_den;
    logic                        div_valid;
    scp_side_t                   div_side;
    logic [DIV_LANES-1:0][63:0]  div_quo;
    logic [DIV_LANES-1:0]        div_sat;

    logic [63:0]      g_val, e_val;
    logic             vf1_reg, vf2_reg;
    scp_side_t        sf1_reg, sf2_reg;
    logic             gsat1_reg, esat1_reg, gsat2_reg, esat2_reg;
    logic [2:0][63:0] flo1_reg, fhi1_reg;
    logic [63:0]      e1_reg, e2_reg;
    logic [2:0][52:0] f2_reg;
    logic [64:0]      fsum [3];

    logic [48:0] pk_x, pk_y, pk_z, pk_e;
    logic        m_valid_reg, m_error_reg;
    logic [47:0] m_force_x_reg, m_force_y_reg, m_force_z_reg, m_energy_reg;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefactor_reg <= PREFACTOR_RST;
            kappa_reg     <= KAPPA_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PREFACTOR: prefactor_reg <= cfg_data;
                REG_KAPPA:     kappa_reg     <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        qa_mag   = s_charge_a[23] ? (24'd0 - s_charge_a) : s_charge_a;
        qb_mag   = s_charge_b[23] ? (24'd0 - s_charge_b) : s_charge_b;
        dir_u[0] = s_dir_x[31] ? (32'd0 - s_dir_x) : s_dir_x;
        dir_u[1] = s_dir_y[31] ? (32'd0 - s_dir_y) : s_dir_y;
        dir_u[2] = s_dir_z[31] ? (32'd0 - s_dir_z) : s_dir_z;
        ctx1_next.side.zero  = (s_distance == '0) || (s_distance_squared == '0);
        ctx1_next.side.want  = s_energy_wanted;
        ctx1_next.side.neg_q = s_charge_a[23] ^ s_charge_b[23];
        ctx1_next.side.neg_d = {s_dir_z[31], s_dir_y[31], s_dir_x[31]};
        ctx1_next.side.dm    = dir_u;
        ctx1_next.d2         = s_distance_squared;
        ctx1_next.distance   = s_distance;
        ctx1_next.x          = kappa_reg * s_distance;
        ctx1_next.w          = s_weight;
    end

    assign s7_sum = {ppb6_reg, 29'd0} + 91'(ppa6_reg);
    assign onepk  = 45'h4000_0000 + 45'(ctx7_reg.x[55:12]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg} <= '0;
        end else if (en) begin
            {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg} <=
                {s_valid, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx1_reg <= ctx1_next;
            qq1_reg  <= qa_mag * qb_mag;

            ctx2_reg <= ctx1_reg;
            y2_reg   <= ctx1_reg.x[55:26] * LOG2E_Q30;
            ppa2_reg <= qq1_reg[23:0] * prefactor_reg;
            ppb2_reg <= qq1_reg[47:24] * prefactor_reg;

            ctx3_reg <= ctx2_reg;
            p1_3_reg <= ppb2_reg + (ppa2_reg >> 24);
            n3_reg   <= y2_reg[60:46];
            tab3_reg <= EXP_TAB[y2_reg[45 -: EXP_IDX_W]];

            ctx4_reg <= ctx3_reg;
            ex4_reg  <= (n3_reg > EXP_N_MAX) ? 33'd0 : (tab3_reg >> n3_reg);
            ppa4_reg <= p1_3_reg[27:0] * ctx3_reg.w;
            ppb4_reg <= p1_3_reg[55:28] * ctx3_reg.w;

            ctx5_reg <= ctx4_reg;
            ex5_reg  <= ex4_reg;
            p2_5_reg <= {ppb4_reg, 12'd0} + 58'(ppa4_reg[45:16]);

            ctx6_reg <= ctx5_reg;
            ppa6_reg <= p2_5_reg[28:0] * ex5_reg;
            ppb6_reg <= p2_5_reg[57:29] * ex5_reg;

            ctx7_reg <= ctx6_reg;
            p3_7_reg <= s7_sum[90:32];

            ctx8_reg <= ctx7_reg;
            p3_8_reg <= p3_7_reg;
            ac8_reg  <= p3_7_reg[29:0] * onepk[22:0];
            ad8_reg  <= p3_7_reg[29:0] * onepk[44:23];
            bc8_reg  <= p3_7_reg[58:30] * onepk[22:0];
            bd8_reg  <= p3_7_reg[58:30] * onepk[44:23];

            ctx9_reg  <= ctx8_reg;
            p3_9_reg  <= p3_8_reg;
            prod9_reg <= 104'(ac8_reg) + 104'({ad8_reg, 23'd0})
                       + 104'({bc8_reg, 30'd0}) + {bd8_reg, 53'd0};
        end
    end

    always_comb begin
        div_num[LANE_G] = {24'd0, prod9_reg};
        div_den[LANE_G] = ctx9_reg.d2;
        div_num[LANE_E] = {57'd0, p3_9_reg, 12'd0};
        div_den[LANE_E] = {16'd0, ctx9_reg.distance};
    end

    scp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v9_reg),
        .in_side   (ctx9_reg.side),
        .in_num    (div_num),
        .in_den    (div_den),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quo   (div_quo),
        .out_sat   (div_sat)
    );

    assign g_val = div_sat[LANE_G] ? '1 : div_quo[LANE_G];
    assign e_val = div_sat[LANE_E] ? '1 : div_quo[LANE_E];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fsum[c] = 65'(fhi1_reg[c]) + 65'(flo1_reg[c][63:32]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf1_reg <= 1'b0;
            vf2_reg <= 1'b0;
        end else if (en) begin
            vf1_reg <= div_valid;
            vf2_reg <= vf1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sf1_reg   <= div_side;
            gsat1_reg <= div_sat[LANE_G];
            esat1_reg <= div_sat[LANE_E];
            e1_reg    <= e_val;
            for (int c = 0; c < 3; c++) begin
                flo1_reg[c] <= g_val[31:0] * div_side.dm[c];
                fhi1_reg[c] <= g_val[63:32] * div_side.dm[c];
            end

            sf2_reg   <= sf1_reg;
            gsat2_reg <= gsat1_reg;
            esat2_reg <= esat1_reg;
            e2_reg    <= e1_reg;
            for (int c = 0; c < 3; c++) begin
                f2_reg[c] <= fsum[c][64:12];
            end
        end
    end

    assign pk_x = scp_pack({11'd0, f2_reg[0]}, sf2_reg.neg_q ^ sf2_reg.neg_d[0]);
    assign pk_y = scp_pack({11'd0, f2_reg[1]}, sf2_reg.neg_q ^ sf2_reg.neg_d[1]);
    assign pk_z = scp_pack({11'd0, f2_reg[2]}, sf2_reg.neg_q ^ sf2_reg.neg_d[2]);
    assign pk_e = scp_pack(e2_reg, sf2_reg.neg_q);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vf2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sf2_reg.zero) begin
                m_force_x_reg <= '0;
                m_force_y_reg <= '0;
                m_force_z_reg <= '0;
                m_energy_reg  <= '0;
                m_error_reg   <= 1'b1;
            end else begin
                m_force_x_reg <= pk_x[47:0];
                m_force_y_reg <= pk_y[47:0];
                m_force_z_reg <= pk_z[47:0];
                m_energy_reg  <= sf2_reg.want ? pk_e[47:0] : 48'd0;
                m_error_reg   <= gsat2_reg | pk_x[48] | pk_y[48] | pk_z[48]
                               | (sf2_reg.want & (esat2_reg | pk_e[48]));
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_force_x = m_force_x_reg;
    assign m_force_y = m_force_y_reg;
    assign m_force_z = m_force_z_reg;
    assign m_energy  = m_energy_reg;
    assign m_error   = m_error_reg;

    a_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vf2_reg && sf2_reg.zero
        |=> m_error && m_force_x == '0 && m_force_y == '0 && m_energy == '0)
        else $error("zero distance result not flagged");

    a_no_energy: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vf2_reg && !sf2_reg.want |=> m_energy == '0)
        else $error("energy present when not requested");

    a_clamp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_force_x != 48'h8000_0000_0000 && m_energy != 48'h8000_0000_0000)
        else $error("output magnitude beyond clamp");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for screened_coulomb_pair_force: drives pair requests,
// predicts each force/energy result in fixed point, and compares it with the block's output.
// Depends on scp_pkg and the screened_coulomb_pair_force RTL.
`timescale 1ns / 100ps

module testbench;
    import scp_pkg::*;

    typedef struct {
        logic [31:0] distance;
        logic [47:0] dist_sq;
        logic [31:0] dir [3];
        logic [23:0] qa;
        logic [23:0] qb;
        logic [17:0] weight;
        logic        want;
    } pair_t;

    typedef struct {
        logic [47:0] force_v [3];
        logic [47:0] energy;
        logic        error;
    } force_t;

    localparam logic [63:0] LOG2E   = 64'd1549082005;
    localparam logic [63:0] LN2     = 64'd2977044472;
    localparam logic [63:0] FRAC46  = 64'h3FFF_FFFF_FFFF;
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF;
    localparam int          STALL_LIMIT = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [31:0] s_distance = '0;
    logic [47:0] s_distance_squared = '0;
    logic signed [31:0] s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic signed [23:0] s_charge_a = '0, s_charge_b = '0;
    logic [17:0] s_weight = '0;
    logic s_energy_wanted = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [47:0] m_force_x, m_force_y, m_force_z, m_energy;
    logic m_error;

    logic [63:0] exp_lut [EXP_TABLE_DEPTH];
    logic [31:0] prefactor_q = 32'd70885981;
    logic [23:0] kappa_q = 24'd419430;
    force_t      pending_q [$];
    bit          failed = 1'b0;
    bit          rx_fast = 1'b0;
    bit          hold_toggle = 1'b0;
    bit          hold_seen = 1'b0;
    int          rx_wait = 0;
    int          rx_hold = 0;
    int          idle_cycles = 0;

    screened_coulomb_pair_force u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_distance(s_distance),
        .s_distance_squared(s_distance_squared), .s_dir_x(s_dir_x), .s_dir_y(s_dir_y),
        .s_dir_z(s_dir_z), .s_charge_a(s_charge_a), .s_charge_b(s_charge_b),
        .s_weight(s_weight), .s_energy_wanted(s_energy_wanted),
        .m_valid(m_valid), .m_ready(m_ready), .m_force_x(m_force_x),
        .m_force_y(m_force_y), .m_force_z(m_force_z), .m_energy(m_energy),
        .m_error(m_error)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] mul_div(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] d, inout bit sat);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if (prod[127:64] >= d) begin
            sat = 1'b1;
            return '1;
        end
        return 64'(prod / {64'd0, d});
    endfunction

    function automatic logic [47:0] clamp_sign(input logic [63:0] mag, input bit neg,
                                               inout bit sat);
        logic [47:0] m;
        if (mag > MAG_MAX) begin
            mag = MAG_MAX;
            sat = 1'b1;
        end
        m = mag[47:0];
        return neg ? 48'd0 - m : m;
    endfunction

    function automatic force_t screened_force(input pair_t p);
        force_t      r;
        bit          na, nb, nd, sat, ignore;
        logic [63:0] qa, qb, x, y, n, idx, ex, pw, onepk, g, dm;
        r.force_v = '{48'd0, 48'd0, 48'd0};
        r.energy = '0;
        r.error = 1'b0;
        if (p.distance == 0 || p.dist_sq == 0) begin
            r.error = 1'b1;
            return r;
        end
        sat = 1'b0;
        ignore = 1'b0;
        na = p.qa[23];
        nb = p.qb[23];
        qa = {40'd0, na ? 24'd0 - p.qa : p.qa};
        qb = {40'd0, nb ? 24'd0 - p.qb : p.qb};
        x = {40'd0, kappa_q} * {32'd0, p.distance};
        y = (x >> 26) * LOG2E;
        n = y >> 46;
        idx = ((y & FRAC46) * EXP_TABLE_DEPTH) >> 46;
        ex = (n > 32) ? 64'd0 : (exp_lut[idx] >> n);
        pw = mul_div(qa * qb, {32'd0, prefactor_q}, 64'd1 << 24, ignore);
        pw = mul_div(pw, {46'd0, p.weight}, 64'd1 << 16, ignore);
        pw = mul_div(pw, ex, 64'd1 << 32, ignore);
        onepk = (64'd1 << 30) + (x >> 12);
        g = mul_div(pw, onepk, {16'd0, p.dist_sq}, sat);
        for (int c = 0; c < 3; c++) begin
            nd = p.dir[c][31];
            dm = {32'd0, nd ? 32'd0 - p.dir[c] : p.dir[c]};
            r.force_v[c] = clamp_sign(mul_div(g, dm, 64'd1 << 44, sat), (na != nb) != nd, sat);
        end
        if (p.want) begin
            r.energy = clamp_sign(mul_div(pw, 64'd1 << 12, {32'd0, p.distance}, sat),
                                  na != nb, sat);
        end
        r.error = sat;
        return r;
    endfunction

    task automatic fill_exp_lut();
        logic [63:0] t, term, sum;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            t = (64'(i) * LN2) / EXP_TABLE_DEPTH;
            term = 64'd1 << 32;
            sum = 64'd1 << 32;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * t) >> 32) / 64'(k);
                sum = (k % 2) ? sum - term : sum + term;
            end
            exp_lut[i] = sum;
        end
    endtask

    // result receiver: random stalls, optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            rx_hold <= 400;
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1) begin
                m_ready <= 1'b1;
            end
        end else if (m_ready) begin
            if (m_valid) begin
                rx_wait = rx_fast ? 0 : $urandom_range(0, 9);
                if (rx_wait > 0) begin
                    m_ready <= 1'b0;
                end
            end
        end else if (rx_wait <= 1) begin
            m_ready <= 1'b1;
        end else begin
            rx_wait = rx_wait - 1;
        end
    end

    always @(posedge aclk) begin
        force_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result fx=%h", $time, m_force_x);
                failed = 1'b1;
            end else begin
                e = pending_q.pop_front();
                if (m_force_x !== e.force_v[0] || m_force_y !== e.force_v[1] ||
                    m_force_z !== e.force_v[2] || m_energy !== e.energy ||
                    m_error !== e.error) begin
                    $display("%0t: mismatch expected f=(%h %h %h) e=%h err=%b", $time,
                             e.force_v[0], e.force_v[1], e.force_v[2], e.energy, e.error);
                    $display("%0t:           actual f=(%h %h %h) e=%h err=%b", $time,
                             m_force_x, m_force_y, m_force_z, m_energy, m_error);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pair(input pair_t p, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_distance <= p.distance;
        s_distance_squared <= p.dist_sq;
        s_dir_x <= p.dir[0];
        s_dir_y <= p.dir[1];
        s_dir_z <= p.dir[2];
        s_charge_a <= p.qa;
        s_charge_b <= p.qb;
        s_weight <= p.weight;
        s_energy_wanted <= p.want;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_q.push_back(screened_force(p));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == REG_PREFACTOR) begin
            prefactor_q = data;
        end else begin
            kappa_q = data[23:0];
        end
    endtask

    function automatic pair_t make_pair(input logic [31:0] r, input logic [47:0] r2,
                                        input logic [31:0] ex, input logic [31:0] ey,
                                        input logic [31:0] ez, input logic [23:0] q1,
                                        input logic [23:0] q2, input logic [17:0] w,
                                        input bit want);
        pair_t p;
        p.distance = r;
        p.dist_sq = r2;
        p.dir = '{ex, ey, ez};
        p.qa = q1;
        p.qb = q2;
        p.weight = w;
        p.want = want;
        return p;
    endfunction

    function automatic pair_t random_pair();
        pair_t       p;
        logic [63:0] r;
        if ($urandom_range(0, 3) == 0) begin
            p = make_pair($urandom, 48'({$urandom, $urandom}), $urandom, $urandom, $urandom,
                          24'($urandom), 24'($urandom), 18'($urandom), 1'($urandom));
            if ($urandom_range(0, 15) == 0) begin
                p.dist_sq = '0;
            end
        end else begin
            r = 64'($urandom_range(1 << 16, 1 << 26));
            p = make_pair(r[31:0], 48'((r * r) >> 16),
                          32'($signed($urandom_range(0, 1 << 31)) - (1 << 30)),
                          32'($signed($urandom_range(0, 1 << 31)) - (1 << 30)),
                          32'($signed($urandom_range(0, 1 << 31)) - (1 << 30)),
                          24'($urandom), 24'($urandom), 18'($urandom_range(0, 1 << 17)),
                          1'($urandom));
        end
        return p;
    endfunction

    task automatic test_directed();
        send_pair(make_pair(32'd0, 48'd1 << 24, 32'd1 << 30, 32'd0, 32'd0, 24'd1 << 16,
                            24'd1 << 16, 18'd1 << 16, 1'b1));
        send_pair(make_pair(32'd1 << 20, 48'd0, 32'd1 << 30, 32'd0, 32'd0, 24'd1 << 16,
                            24'd1 << 16, 18'd1 << 16, 1'b1));
        send_pair(make_pair(32'd0, 48'd0, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0, 18'd0, 1'b0));
        send_pair(make_pair(32'd1 << 20, 48'd1 << 24, 32'd1 << 30, 32'd0, 32'd0, 24'd1 << 16,
                            24'd1 << 16, 18'd1 << 16, 1'b1));
        send_pair(make_pair(32'd1 << 20, 48'd1 << 24, 32'd0, 32'd1 << 30, 32'd0, 24'd1 << 16,
                            24'hFF0000, 18'd1 << 16, 1'b0));
        send_pair(make_pair(32'd1 << 20, 48'd1 << 24, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hC000_0000, 24'h800000, 24'h800000, 18'h3FFFF, 1'b1));
        send_pair(make_pair(32'd1, 48'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            24'h7FFFFF, 24'h800000, 18'h3FFFF, 1'b1));
        send_pair(make_pair(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd1 << 30, 32'd1 << 30,
                            32'd1 << 30, 24'h7FFFFF, 24'h7FFFFF, 18'h3FFFF, 1'b1));
        send_pair(make_pair(32'd50 << 20, 48'd2500 << 24, 32'd1 << 30, 32'd0, 32'd0,
                            24'h7FFFFF, 24'h7FFFFF, 18'd1 << 16, 1'b1));
        send_pair(make_pair(32'd1 << 18, 48'd1 << 20, 32'hF000_0000, 32'd1 << 29,
                            32'h0FFF_FFFF, 24'h010000, 24'hFF8000, 18'd0, 1'b1));
        send_pair(make_pair(32'd3 << 19, 48'd9 << 22, 32'd1 << 30, 32'd0, 32'd0, 24'd1,
                            24'hFFFFFF, 18'd1 << 16, 1'b1));
        send_pair(make_pair(32'd1 << 20, 48'd1 << 24, 32'd1 << 30, 32'd0, 32'd0, 24'd0,
                            24'h7FFFFF, 18'd1 << 16, 1'b1));
    endtask

    task automatic test_random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 50) begin
                rx_fast <= ~rx_fast;
            end
            send_pair(random_pair(), i % 100 >= 60 && i % 100 < 80);
        end
    endtask

    task automatic test_backpressure();
        hold_toggle <= ~hold_toggle;
        for (int i = 0; i < 150; i++) begin
            send_pair(random_pair(), 1'b1);
        end
        drain();
        for (int i = 0; i < 50; i++) begin
            send_pair(random_pair());
        end
    endtask

    task automatic test_config_sweep();
        write_reg(REG_PREFACTOR, 32'hFFFF_FFFF);
        write_reg(REG_KAPPA, 32'd0);
        test_directed();
        test_random_phase(250);
        write_reg(REG_PREFACTOR, 32'd0);
        write_reg(REG_KAPPA, 32'h00FF_FFFF);
        test_random_phase(100);
        write_reg(REG_PREFACTOR, 32'd1 << 24);
        write_reg(REG_KAPPA, 32'hFFFF_FFFF);
        test_directed();
        test_random_phase(250);
        write_reg(REG_PREFACTOR, $urandom);
        write_reg(REG_KAPPA, $urandom);
        test_random_phase(200);
    endtask

    initial begin
        fill_exp_lut();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(300);
        test_backpressure();
        test_config_sweep();
        drain();
        if (failed) begin
            $display("TEST FAILED");
        end else begin
            $display("TEST PASSED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/scp_pkg.sv
rtl/scp_div.sv
rtl/screened_coulomb_pair_force.sv
tb/sv/testbench.sv
